// ===== rtl/core/indexed_array_list_core_macros.svh =====
// ----------------------------------------------------------------------------
// Indexed array list assertion macros
// Shared assertion wrappers for the list core.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_LIST_CORE_MACROS_SVH
`define INDEXED_ARRAY_LIST_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define IAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IAL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/ial_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed array list package
// Operation codes, status codes, control state and the cell control word.
// ----------------------------------------------------------------------------
package ial_pkg;

  typedef enum logic [2:0] {
    FUNC_APPEND     = 3'd0,
    FUNC_INSERT_AT  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_REMOVE_AT  = 3'd4,
    FUNC_READ_AT    = 3'd5,
    FUNC_FIND       = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_EMPTY  = 2'd2,
    STATUS_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SHIFT_NONE = 2'd0,
    SHIFT_INS  = 2'd1,
    SHIFT_DEL  = 2'd2
  } shift_e;

  typedef enum logic {
    FSM_IDLE   = 1'b0,
    FSM_REDUCE = 1'b1
  } fsm_e;

  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 5;
  localparam int unsigned CountW = 6;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic   go;
    shift_e shift;
    logic   find;
  } cell_ctl_t;

endpackage

// ===== rtl/core/ial_in_if.sv =====
// ----------------------------------------------------------------------------
// Indexed array list request channel
// Valid/ready channel carrying one list operation.
// ----------------------------------------------------------------------------
interface ial_in_if;
  logic                valid;
  logic                ready;
  ial_pkg::func_e      func;
  logic [4:0]          position;
  logic signed [31:0]  item_value;

  modport source (output valid, func, position, item_value, input ready);
  modport sink   (input valid, func, position, item_value, output ready);
endinterface

// ===== rtl/core/ial_out_if.sv =====
// ----------------------------------------------------------------------------
// Indexed array list response channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface ial_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  value_out;
  logic [4:0]          position_out;
  logic                found;
  ial_pkg::status_e    status;
  logic [5:0]          count_out;

  modport source (output valid, value_out, position_out, found, status, count_out,
                  input ready);
  modport sink   (input valid, value_out, position_out, found, status, count_out,
                  output ready);
endinterface

// ===== rtl/core/ial_cell.sv =====
// ----------------------------------------------------------------------------
// Indexed array list cell
// Holds one list entry, shifts with its neighbours and reports a tap and a match.
// ----------------------------------------------------------------------------
module ial_cell #(
  parameter int unsigned CW    = 6,
  parameter int unsigned INDEX = 0
) (
  input  logic               clk_i,
  input  ial_pkg::cell_ctl_t ctl_i,
  input  logic [CW-1:0]      idx_i,
  input  logic [CW-1:0]      count_i,
  input  logic [31:0]        value_i,
  input  logic [31:0]        left_i,
  input  logic [31:0]        right_i,
  output logic [31:0]        entry_o,
  output logic [31:0]        tap_o,
  output logic               match_o
);
  import ial_pkg::*;

  localparam logic [CW-1:0] MyIdx = CW'(INDEX);

  logic [WordW-1:0] entry_q, entry_d;
  logic [WordW-1:0] tap_q;
  logic             match_q;

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.shift)
      SHIFT_INS: begin
        if (MyIdx > idx_i) begin
          entry_d = left_i;
        end else if (MyIdx == idx_i) begin
          entry_d = value_i;
        end
      end
      SHIFT_DEL: begin
        if (MyIdx >= idx_i) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  // The tap and match sample the contents before this transfer's update.
  always_ff @(posedge clk_i) begin
    if (ctl_i.go) begin
      entry_q <= entry_d;
      tap_q   <= (MyIdx == idx_i) ? entry_q : '0;
      match_q <= ctl_i.find && (MyIdx < count_i) && (entry_q == value_i);
    end
  end

  assign entry_o = entry_q;
  assign tap_o   = tap_q;
  assign match_o = match_q;
endmodule

// ===== rtl/core/ial_reduce.sv =====
// ----------------------------------------------------------------------------
// Indexed array list result reduction
// Merges the cell taps and finds the lowest matching cell.
// ----------------------------------------------------------------------------
module ial_reduce #(
  parameter int unsigned CAPACITY = 32,
  parameter int unsigned IW       = 5
) (
  input  logic [CAPACITY-1:0][31:0] taps_i,
  input  logic [CAPACITY-1:0]       match_i,
  output logic [31:0]               value_o,
  output logic                      found_o,
  output logic [IW-1:0]             index_o
);
  import ial_pkg::*;

  always_comb begin
    value_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      value_o = value_o | taps_i[i];
    end
  end

  // Scanning downwards leaves the lowest matching position.
  always_comb begin
    index_o = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        index_o = IW'(i);
      end
    end
  end

  assign found_o = |match_i;
endmodule

// ===== rtl/core/indexed_array_list_core.sv =====
// ----------------------------------------------------------------------------
// Indexed array list core
// Ordered list of signed words held in a chain of cells, with insert, remove,
// read and search.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_i      sink       func, position, item_value
//  out_o     source     value_out, position_out, found, status, count_out
//
//  The cells shift and sample in the cycle of the input transfer; the tap merge
//  and match search then fill the output register from the cell registers once
//  the output register is free. The next input is taken after that load.
//  Reset clears the entry count and the control state; cell contents are not
//  reset. A stalled output holds the core in its reduce state.
// ----------------------------------------------------------------------------
`include "indexed_array_list_core_macros.svh"

module indexed_array_list_core #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  ial_in_if.sink    in_i,
  ial_out_if.source out_o
);
  import ial_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = (CW > PosW) ? CW : PosW;
  localparam logic [CW-1:0] CapVal = CW'(CAPACITY);

  fsm_e state_q, state_d;
  logic accept;
  logic load_out;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx;
  cell_ctl_t     ctl;
  status_e       status_d;
  logic          has_val_d;

  logic          pend_has_val_q;
  logic          pend_find_q;
  status_e       pend_status_q;
  logic [CountW-1:0] pend_count_q;

  logic              out_valid_q;
  logic [WordW-1:0]  out_value_q;
  logic [PosW-1:0]   out_pos_q;
  logic              out_found_q;
  status_e           out_status_q;
  logic [CountW-1:0] out_count_q;

  logic [CAPACITY-1:0][WordW-1:0] entry_w;
  logic [CAPACITY-1:0][WordW-1:0] tap_w;
  logic [CAPACITY-1:0]            match_w;
  logic [WordW-1:0]               red_value;
  logic                           red_found;
  logic [IW-1:0]                  red_index;

  logic full, empty, ins_bad, at_bad;
  logic [PW-1:0] pos_w, cnt_w;

  assign in_i.ready = (state_q == FSM_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign load_out   = (state_q == FSM_REDUCE) && (!out_valid_q || out_o.ready);

  assign full    = (cnt_q == CapVal);
  assign empty   = (cnt_q == '0);
  assign pos_w   = PW'(in_i.position);
  assign cnt_w   = PW'(cnt_q);
  assign ins_bad = (pos_w > cnt_w);
  assign at_bad  = (pos_w >= cnt_w);

  always_comb begin
    status_d  = STATUS_OK;
    ctl.go    = accept;
    ctl.shift = SHIFT_NONE;
    ctl.find  = 1'b0;
    idx       = '0;
    has_val_d = 1'b0;
    cnt_d     = cnt_q;
    case (in_i.func)
      FUNC_APPEND: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          ctl.shift = SHIFT_INS;
          idx       = cnt_q;
          cnt_d     = cnt_q + CW'(1);
        end
      end
      FUNC_INSERT_AT: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else if (ins_bad) begin
          status_d = STATUS_BADPOS;
        end else begin
          ctl.shift = SHIFT_INS;
          idx       = CW'(in_i.position);
          cnt_d     = cnt_q + CW'(1);
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          ctl.shift = SHIFT_DEL;
          has_val_d = 1'b1;
          cnt_d     = cnt_q - CW'(1);
        end
      end
      FUNC_POP_BACK: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          idx       = cnt_q - CW'(1);
          has_val_d = 1'b1;
          cnt_d     = cnt_q - CW'(1);
        end
      end
      FUNC_REMOVE_AT: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else if (at_bad) begin
          status_d = STATUS_BADPOS;
        end else begin
          ctl.shift = SHIFT_DEL;
          idx       = CW'(in_i.position);
          has_val_d = 1'b1;
          cnt_d     = cnt_q - CW'(1);
        end
      end
      FUNC_READ_AT: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else if (at_bad) begin
          status_d = STATUS_BADPOS;
        end else begin
          idx       = CW'(in_i.position);
          has_val_d = 1'b1;
        end
      end
      FUNC_FIND: ctl.find = 1'b1;
      default: status_d = STATUS_OK;
    endcase
  end

  // Cells only move on a transfer, so gate the shift with it.
  cell_ctl_t cell_ctl;
  always_comb begin
    cell_ctl       = ctl;
    cell_ctl.shift = accept ? ctl.shift : SHIFT_NONE;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WordW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = entry_w[i];
    end else begin : g_mid_r
      assign right_w = entry_w[i+1];
    end
    ial_cell #(
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .idx_i   (idx),
      .count_i (cnt_q),
      .value_i (in_i.item_value),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[i]),
      .tap_o   (tap_w[i]),
      .match_o (match_w[i])
    );
  end

  ial_reduce #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_reduce (
    .taps_i  (tap_w),
    .match_i (match_w),
    .value_o (red_value),
    .found_o (red_found),
    .index_o (red_index)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE:   if (accept) state_d = FSM_REDUCE;
      FSM_REDUCE: if (load_out) state_d = FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_has_val_q <= has_val_d;
      pend_find_q    <= ctl.find;
      pend_status_q  <= status_d;
      pend_count_q   <= CountW'(cnt_d);
    end
    if (load_out) begin
      out_value_q  <= pend_has_val_q ? red_value : '0;
      out_found_q  <= pend_find_q && red_found;
      out_pos_q    <= (pend_find_q && red_found) ? PosW'(red_index) : '0;
      out_status_q <= pend_status_q;
      out_count_q  <= pend_count_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.value_out    = out_value_q;
  assign out_o.position_out = out_pos_q;
  assign out_o.found        = out_found_q;
  assign out_o.status       = out_status_q;
  assign out_o.count_out    = out_count_q;

  `IAL_ASSERT(a_accept_to_reduce, accept |=> (state_q == FSM_REDUCE), "transfer did not start reduction")
  `IAL_ASSERT(a_count_bound, cnt_q <= CapVal, "entry count beyond capacity")
  `IAL_ASSERT(a_count_stable, !accept |=> $stable(cnt_q), "entry count moved without a transfer")
  `IAL_ASSERT(a_pend_count, (state_q == FSM_REDUCE) |-> (pend_count_q == CountW'(cnt_q)), "pending count disagrees with list")
  `IAL_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (state_q == FSM_IDLE && !out_valid_q), "control not cleared in reset")
endmodule

// ===== dv/ial_list_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed array list checker
// Watches both channels of the list core. It keeps its own copy of the list,
// works out the result of every accepted operation and compares each result
// transfer with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module ial_list_checker #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ial_in_if           in_mon_i,
  ial_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import ial_pkg::*;

  typedef struct packed {
    logic signed [31:0] word;
    logic [4:0]         index;
    logic               hit;
    status_e            status;
    logic [5:0]         fill;
  } list_result_t;

  logic signed [31:0] list_words [CAPACITY];
  int unsigned        list_len;
  list_result_t       result_q [$];
  int unsigned        fail_total = 0;

  // Applies one operation to the shadow list and returns its result.
  task automatic apply_list_op(input logic [2:0] op, input logic [4:0] pos,
                               input logic signed [31:0] val,
                               output list_result_t res);
    int unsigned k;
    res = '0;
    res.status = STATUS_OK;
    case (op)
      FUNC_APPEND: begin
        if (list_len >= CAPACITY) res.status = STATUS_FULL;
        else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      FUNC_INSERT_AT: begin
        if (list_len >= CAPACITY) res.status = STATUS_FULL;
        else if (pos > list_len) res.status = STATUS_BADPOS;
        else begin
          for (k = list_len; k > pos; k--) list_words[k] = list_words[k - 1];
          list_words[pos] = val;
          list_len++;
        end
      end
      FUNC_POP_FRONT: begin
        if (list_len == 0) res.status = STATUS_EMPTY;
        else begin
          res.word = list_words[0];
          for (k = 0; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
          list_len--;
        end
      end
      FUNC_POP_BACK: begin
        if (list_len == 0) res.status = STATUS_EMPTY;
        else begin
          list_len--;
          res.word = list_words[list_len];
        end
      end
      FUNC_REMOVE_AT: begin
        if (list_len == 0) res.status = STATUS_EMPTY;
        else if (pos >= list_len) res.status = STATUS_BADPOS;
        else begin
          res.word = list_words[pos];
          for (k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
          list_len--;
        end
      end
      FUNC_READ_AT: begin
        if (list_len == 0) res.status = STATUS_EMPTY;
        else if (pos >= list_len) res.status = STATUS_BADPOS;
        else res.word = list_words[pos];
      end
      FUNC_FIND: begin
        for (k = 0; k < list_len; k++) begin
          if (!res.hit && list_words[k] == val) begin
            res.hit   = 1'b1;
            res.index = 5'(k);
          end
        end
      end
      default: ;
    endcase
    res.fill = 6'(list_len);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%h, got 0x%h", name, want, got);
      fail_total++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      list_len = 0;
      result_q.delete();
      pending_o <= 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (result_q.size() == 0) begin
          $error("result transfer with no operation outstanding");
          fail_total++;
        end else begin
          want = result_q.pop_front();
          check_field("value_out", want.word, out_mon_i.value_out);
          check_field("position_out", 32'(want.index), 32'(out_mon_i.position_out));
          check_field("found", 32'(want.hit), 32'(out_mon_i.found));
          check_field("status", 32'(want.status), 32'(out_mon_i.status));
          check_field("count_out", 32'(want.fill), 32'(out_mon_i.count_out));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        apply_list_op(in_mon_i.func, in_mon_i.position, in_mon_i.item_value, want);
        result_q.push_back(want);
      end
      pending_o <= result_q.size();
    end
    fail_count_o <= fail_total;
  end

endmodule

// ===== dv/tb_indexed_array_list_core.sv =====
// ----------------------------------------------------------------------------
// Indexed array list core testbench
// Drives list operations into the core, first a directed set covering the
// empty and out-of-range cases, then random operation mixes that grow
// and shrink the list, under several patterns of sender and receiver stalls.
// Results are checked by the list checker instantiated beside the core.
// ----------------------------------------------------------------------------
module tb_indexed_array_list_core;
  import ial_pkg::*;

  localparam logic [2:0]  FuncSpare     = 3'd7;
  localparam int unsigned TimeoutCycles = 600_000;

  typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_e;

  logic        clk;
  logic        rst_n;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count;
  int unsigned pending;

  ial_in_if  in_ch ();
  ial_out_if out_ch ();

  indexed_array_list_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  ial_list_checker checker_u (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon_i    (in_ch),
    .out_mon_i   (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Holds the operation until its transfer, then idles at random.
  task automatic send_op(input logic [2:0] op, input logic [4:0] pos,
                         input logic signed [31:0] val);
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func_e'(op);
    in_ch.position   <= pos;
    in_ch.item_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [2:0] pick_func(op_mix_e mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return FuncSpare;
    case (mix)
      MIX_GROW: begin
        if (r < 45) return FUNC_APPEND;
        if (r < 72) return FUNC_INSERT_AT;
        if (r < 78) return FUNC_POP_FRONT;
        if (r < 84) return FUNC_POP_BACK;
        if (r < 90) return FUNC_REMOVE_AT;
        if (r < 95) return FUNC_READ_AT;
        return FUNC_FIND;
      end
      MIX_SHRINK: begin
        if (r < 25) return FUNC_POP_FRONT;
        if (r < 48) return FUNC_POP_BACK;
        if (r < 70) return FUNC_REMOVE_AT;
        if (r < 78) return FUNC_APPEND;
        if (r < 84) return FUNC_INSERT_AT;
        if (r < 92) return FUNC_READ_AT;
        return FUNC_FIND;
      end
      default: return 3'($urandom_range(0, 6));
    endcase
  endfunction

  // A small pool of words makes searches hit often; the rest is full range.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int unsigned n_ops, int unsigned idle_pct, int unsigned stall_pct);
    op_mix_e     mix;
    int unsigned stretch;
    logic [4:0]  pos;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stretch = 0;
    mix = MIX_EVEN;
    repeat (n_ops) begin
      if (stretch == 0) begin
        mix = op_mix_e'($urandom_range(0, 2));
        stretch = $urandom_range(20, 60);
      end
      stretch--;
      pos = $urandom_range(0, 1) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 15));
      send_op(pick_func(mix), pos, pick_word());
    end
    wait_all_results();
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_APPEND;
    in_ch.position   <= '0;
    in_ch.item_value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Operations on an empty list.
    send_op(FUNC_READ_AT, 5'd0, 32'sd0);
    send_op(FUNC_POP_FRONT, 5'd0, 32'sd0);
    send_op(FUNC_POP_BACK, 5'd0, 32'sd0);
    send_op(FUNC_REMOVE_AT, 5'd0, 32'sd0);
    send_op(FUNC_FIND, 5'd0, 32'sd0);
    send_op(FUNC_INSERT_AT, 5'd1, 32'sd5);
    // Extreme words, inserts at the front, at the end and past it.
    send_op(FUNC_APPEND, 5'd31, 32'sh7fff_ffff);
    send_op(FUNC_APPEND, 5'd0, 32'sh8000_0000);
    send_op(FUNC_INSERT_AT, 5'd0, 32'sd0);
    send_op(FUNC_INSERT_AT, 5'd3, -32'sd1);
    send_op(FUNC_INSERT_AT, 5'd31, 32'sd7);
    send_op(FUNC_READ_AT, 5'd0, 32'sd0);
    send_op(FUNC_READ_AT, 5'd4, 32'sd0);
    send_op(FUNC_READ_AT, 5'd31, 32'sd0);
    send_op(FUNC_FIND, 5'd0, -32'sd1);
    send_op(FUNC_FIND, 5'd0, 32'sh8000_0000);
    send_op(FUNC_FIND, 5'd0, 32'sd12345);
    send_op(FuncSpare, 5'd31, '1);
    send_op(FUNC_REMOVE_AT, 5'd4, 32'sd0);
    send_op(FUNC_REMOVE_AT, 5'd1, 32'sd0);
    send_op(FUNC_POP_FRONT, 5'd0, 32'sd0);
    send_op(FUNC_POP_BACK, 5'd0, 32'sd0);
    send_op(FUNC_POP_BACK, 5'd0, 32'sd0);
    wait_all_results();

    // The sender pauses until every result has arrived between phases.
    run_random(250, 0, 0);
    run_random(210, 77, 0);
    run_random(210, 0, 77);
    run_random(230, 15, 15);

    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #(TimeoutCycles * 12);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
